>>> design/rsti_pkg.sv
// Shared types, character codes and digit decode for the radix string-to-integer unit.
// No dependencies; imported by rsti_step, radix_string_to_integer_unit and tb_top.
package rsti_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned RadixWidth = 6;

	localparam logic [RadixWidth-1:0] RadixReset = 6'd10;
	localparam logic [RadixWidth-1:0] RadixHex   = 6'd16;

	localparam logic [7:0] ChNul   = 8'd0;
	localparam logic [7:0] ChTab   = 8'd9;
	localparam logic [7:0] ChLf    = 8'd10;
	localparam logic [7:0] ChSpace = 8'd32;
	localparam logic [7:0] ChPlus  = 8'd43;
	localparam logic [7:0] ChMinus = 8'd45;
	localparam logic [7:0] ChZero  = 8'd48;
	localparam logic [7:0] ChNine  = 8'd57;
	localparam logic [7:0] ChUpA   = 8'd65;
	localparam logic [7:0] ChUpZ   = 8'd90;
	localparam logic [7:0] ChLoA   = 8'd97;
	localparam logic [7:0] ChLoX   = 8'd120;
	localparam logic [7:0] ChLoZ   = 8'd122;
	localparam logic [7:0] UpOffset = 8'd55;
	localparam logic [7:0] LoOffset = 8'd87;

	localparam logic [1:0] CountMax = 2'd2;

	typedef struct packed {
		logic [ValueWidth-1:0] acc;
		logic [1:0]            cnt;
		logic                  neg;
		logic                  pre;
		logic                  stop;
	} parse_state_t;

	typedef struct packed {
		logic                  valid;
		logic [ValueWidth-1:0] value;
		logic                  had_digits;
	} result_t;

	localparam parse_state_t ParseReset = '{
		acc:  '0,
		cnt:  2'd0,
		neg:  1'b0,
		pre:  1'b1,
		stop: 1'b0
	};

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} digit_t;

	// Alphanumeric decode; a digit must also lie below the radix.
	function automatic digit_t decode_digit(input logic [7:0] c, input logic [RadixWidth-1:0] r);
		digit_t     d;
		logic [7:0] v;
		logic       alnum;
		v     = 8'd0;
		alnum = 1'b1;
		if (c inside {[ChZero:ChNine]})
			v = c - ChZero;
		else if (c inside {[ChUpA:ChUpZ]})
			v = c - UpOffset;
		else if (c inside {[ChLoA:ChLoZ]})
			v = c - LoOffset;
		else
			alnum = 1'b0;
		d.val = v[5:0];
		d.ok  = alnum && (v[5:0] < r);
		return d;
	endfunction

endpackage

>>> design/rsti_step.sv
// Per-character parse step: next parse state and the result for a terminating NUL.
// Depends on rsti_pkg.
module rsti_step import rsti_pkg::*; (
	input  logic [7:0]            ch,
	input  logic [RadixWidth-1:0] radix,
	input  parse_state_t          cur,
	output parse_state_t          nxt,
	output result_t               res
);

	digit_t                  dig;
	logic [ValueWidth-1:0]   mac;
	logic                    is_ws;
	logic                    is_sign;
	logic                    is_hex_x;

	always_comb begin
		dig      = decode_digit(ch, radix);
		mac      = ValueWidth'(cur.acc * ValueWidth'(radix)) + ValueWidth'(dig.val);
		is_ws    = ch inside {ChSpace, ChTab, ChLf};
		is_sign  = ch inside {ChPlus, ChMinus};
		is_hex_x = (ch == ChLoX) && (radix == RadixHex) && (cur.cnt == 2'd1) && (cur.acc == '0);

		nxt            = cur;
		res.valid      = 1'b0;
		res.had_digits = (cur.cnt != 2'd0);
		res.value      = '0;
		if (cur.cnt != 2'd0)
			res.value = cur.neg ? (ValueWidth'(0) - cur.acc) : cur.acc;

		if (ch == ChNul) begin
			res.valid = 1'b1;
			nxt       = ParseReset;
		end else if (cur.stop) begin
			nxt = cur;
		end else if (cur.pre && is_ws) begin
			nxt = cur;
		end else if (cur.pre && is_sign) begin
			nxt.pre = 1'b0;
			nxt.neg = (ch == ChMinus);
		end else if (is_hex_x) begin
			// drop the "0x" prefix; skipping and a sign are allowed again
			nxt.cnt = 2'd0;
			nxt.acc = '0;
			nxt.pre = 1'b1;
		end else if (!dig.ok) begin
			nxt.stop = 1'b1;
		end else begin
			nxt.pre = 1'b0;
			nxt.acc = mac;
			if (cur.cnt < CountMax)
				nxt.cnt = cur.cnt + 2'd1;
		end
	end

endmodule

>>> design/radix_string_to_integer_unit.sv
// Top level of the radix string-to-integer unit: input register, parse state, result register.
// Depends on rsti_pkg and rsti_step.
//
// The unit takes one character per cycle while in_ready is high and returns one signed 32-bit
// result for each NUL character; every other character only updates the parse state. A request
// is held in the input register, where a single multiply-add by the radix register updates the
// accumulator, and a NUL then loads the result register, which drives the outputs. Input ready
// drops only when a NUL waits in the input register while the result register still holds an
// untaken result. The radix register is written through cfg_we and cfg_wdata; the user must
// write it only while no string is in flight, as the unit does not enforce this.
module radix_string_to_integer_unit import rsti_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [RadixWidth-1:0]        cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   character,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ValueWidth-1:0] value,
	output logic                         had_digits
);

	logic [RadixWidth-1:0] radix_q;
	logic                  valid_s1;
	logic [7:0]            char_s1;
	parse_state_t          state_q;
	parse_state_t          state_nxt;
	result_t               res;
	logic                  out_valid_q;
	logic [ValueWidth-1:0] value_q;
	logic                  had_digits_q;
	logic                  slot_free;
	logic                  step_fire;

	rsti_step u_step (
		.ch    (char_s1),
		.radix (radix_q),
		.cur   (state_q),
		.nxt   (state_nxt),
		.res   (res)
	);

	assign slot_free = !out_valid_q || out_ready;
	// hold a NUL in the input stage until the result register can take it
	assign step_fire = valid_s1 && (!res.valid || slot_free);
	assign in_ready  = !valid_s1 || step_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RadixReset;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			char_s1 <= character;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ParseReset;
		end else if (step_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= step_fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && step_fire && res.valid) begin
			value_q      <= res.value;
			had_digits_q <= res.had_digits;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign had_digits = had_digits_q;

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !had_digits_q |-> value_q == '0)
		else $error("result without digits carries a nonzero value");

	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire && (char_s1 == ChNul) |=> state_q == ParseReset)
		else $error("parse state not cleared after NUL");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && (char_s1 == ChNul) && out_valid_q && !out_ready)
		else $error("input stalled without a blocked NUL");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cnt != 2'd3)
		else $error("digit count beyond saturation");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for radix_string_to_integer_unit: character streams in, parsed numbers out.
// Depends on rsti_pkg and the unit's RTL; a built-in parser predicts every number.
module tb_top;
	import rsti_pkg::*;

	localparam logic [7:0] ChUpX = "X";
	localparam int unsigned PhaseChars = 135;

	typedef struct {
		logic [ValueWidth-1:0] value;
		logic                  had_digits;
	} parsed_num_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         cfg_we     = 1'b0;
	logic [RadixWidth-1:0]        cfg_wdata  = '0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic [7:0]                   character  = ChNul;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic signed [ValueWidth-1:0] value;
	logic                         had_digits;

	logic [7:0]            text_q[$];
	parsed_num_t           parsed_numbers[$];
	parse_state_t          parser = ParseReset;
	logic [RadixWidth-1:0] model_radix = RadixReset;

	int unsigned errors = 0;
	int unsigned chars_sent = 0;
	int unsigned numbers_checked = 0;
	int unsigned radix_writes = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned stall_cyc = 0;

	radix_string_to_integer_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.character  (character),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.had_digits (had_digits)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Advance the parser by one accepted character; a NUL yields a number.
	task automatic parse_char(input logic [7:0] c);
		parsed_num_t num;
		logic [7:0]  dv;
		logic        alnum;
		dv    = 8'd0;
		alnum = 1'b1;
		if (c == ChNul) begin
			num.had_digits = (parser.cnt != 2'd0);
			num.value      = num.had_digits ? (parser.neg ? -parser.acc : parser.acc) : '0;
			parsed_numbers.push_back(num);
			parser = ParseReset;
		end else if (parser.stop) begin
		end else if (parser.pre && (c == ChSpace || c == ChTab || c == ChLf)) begin
		end else if (parser.pre && (c == ChMinus || c == ChPlus)) begin
			parser.pre = 1'b0;
			parser.neg = (c == ChMinus);
		end else if (c == ChLoX && model_radix == RadixHex && parser.cnt == 2'd1
				&& parser.acc == '0) begin
			// drop the hex prefix and reopen whitespace and sign
			parser.cnt = 2'd0;
			parser.pre = 1'b1;
		end else begin
			if (c >= ChZero && c <= ChNine)
				dv = c - ChZero;
			else if (c >= ChUpA && c <= ChUpZ)
				dv = c - UpOffset;
			else if (c >= ChLoA && c <= ChLoZ)
				dv = c - LoOffset;
			else
				alnum = 1'b0;
			if (!alnum || dv >= {2'b00, model_radix}) begin
				parser.stop = 1'b1;
			end else begin
				parser.pre = 1'b0;
				parser.acc = parser.acc * {26'd0, model_radix} + {24'd0, dv};
				if (parser.cnt != CountMax)
					parser.cnt++;
			end
		end
	endtask

	// Sender: bursts of requests separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			character <= ChNul;
		end else begin
			if (in_valid && in_ready) begin
				parse_char(character);
				chars_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (text_q.size() != 0) begin
					character <= text_q.pop_front();
					in_valid  <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 8);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall pattern rotates through four modes, from always ready to mostly stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			stall_cyc++;
			case ((stall_cyc >> 6) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (stall_cyc % 4 == 0);
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		parsed_num_t num;
		if (arst_n && out_valid && out_ready) begin
			if (parsed_numbers.size() == 0) begin
				flag_mismatch($sformatf("unexpected number %0d", value));
			end else begin
				num = parsed_numbers.pop_front();
				numbers_checked++;
				if (value !== num.value)
					flag_mismatch($sformatf("value %0d, predicted %0d", value,
						$signed(num.value)));
				if (had_digits !== num.had_digits)
					flag_mismatch($sformatf("had_digits %b, predicted %b", had_digits,
						num.had_digits));
			end
		end
	end

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		text_q.push_back(ChNul);
	endtask

	function automatic logic [7:0] digit_char(input int unsigned dv);
		if (dv < 10)
			return ChZero + dv[7:0];
		if ($urandom_range(0, 1) == 0)
			return ChUpA + dv[7:0] - 8'd10;
		return ChLoA + dv[7:0] - 8'd10;
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 2))
			0: return ChSpace;
			1: return ChTab;
			default: return ChLf;
		endcase
	endfunction

	// One string with NUL: mostly well-formed numbers, some noise and broken ones.
	task automatic gen_string();
		int unsigned lim;
		int unsigned ndig;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		lim  = (model_radix == 0) ? 1 : (model_radix > 36) ? 36 : model_radix;
		if (kind == 0) begin
			repeat ($urandom_range(0, 6))
				text_q.push_back(8'($urandom_range(1, 255)));
			text_q.push_back(ChNul);
		end else begin
			repeat ($urandom_range(0, 2))
				text_q.push_back(blank_char());
			if ($urandom_range(0, 2) == 0)
				text_q.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
			if (model_radix == RadixHex && $urandom_range(0, 2) != 0) begin
				text_q.push_back(ChZero);
				text_q.push_back(($urandom_range(0, 7) == 0) ? ChUpX : ChLoX);
				if ($urandom_range(0, 1) == 0)
					text_q.push_back(blank_char());
				if ($urandom_range(0, 2) == 0)
					text_q.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
				if ($urandom_range(0, 4) == 0) begin
					text_q.push_back(ChZero);
					text_q.push_back(ChLoX);
				end
			end
			ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 7);
			for (int i = 0; i < ndig; i++) begin
				// break the sequence now and then with a stray character
				if (kind == 1 && i == ndig / 2)
					text_q.push_back($urandom_range(0, 1) ? blank_char() : ChMinus);
				text_q.push_back(digit_char(($urandom_range(0, 7) == 0)
					? $urandom_range(0, 35) : $urandom_range(0, lim - 1)));
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					text_q.push_back(8'($urandom_range(1, 255)));
			text_q.push_back(ChNul);
		end
	endtask

	task automatic fill_text(input int unsigned target);
		int unsigned start;
		start = text_q.size();
		while (text_q.size() - start < target)
			gen_string();
	endtask

	// Hold until every request is taken and every number has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (text_q.size() != 0 || in_valid || parsed_numbers.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_radix(input logic [RadixWidth-1:0] r);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_radix = r;
		radix_writes++;
		repeat (2) @(negedge clk);
	endtask

	initial begin
		logic [RadixWidth-1:0] radices[12];
		radices = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd8, 6'd0, 6'd1, 6'd63, 6'd37, 6'd16,
			6'd10, 6'd3};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		for (int k = 0; k < 12; k++) begin
			if (k != 0)
				write_radix(radices[k]);
			if (k == 0) begin
				push_text("");
				push_text(" \t\n-7");
				push_text("+-3");
				text_q.push_back(8'hFF);
				text_q.push_back("5");
				text_q.push_back(ChNul);
			end else if (k == 1) begin
				push_text("0x +1f");
				push_text("00x1");
			end
			fill_text(PhaseChars / 2);
			wait_drained();
			fill_text(PhaseChars - PhaseChars / 2);
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (parsed_numbers.size() != 0)
			flag_mismatch($sformatf("%0d numbers never arrived", parsed_numbers.size()));
		$display("Sent %0d characters over %0d radix writes (0, 1, 2..36, 37, 63).",
			chars_sent, radix_writes);
		$display("Checked %0d parsed numbers, %0d mismatches.", numbers_checked, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d numbers outstanding.", parsed_numbers.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/rsti_pkg.sv
design/rsti_step.sv
design/radix_string_to_integer_unit.sv
tb/tb_top.sv
